/* rtl/grid_neighbor_edge_list_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grid neighbor edge list block.
// The assertions sample on clk and are off while rst is high.
// ----------------------------------------------------------------------------
`ifndef GRID_NEIGHBOR_EDGE_LIST_TOP_DEFINES_SVH
`define GRID_NEIGHBOR_EDGE_LIST_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GNEL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid edge check failed");

// Consequent must hold in the cycle after the antecedent.
`define GNEL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid edge check failed");

`endif

/* rtl/gnel_pkg.sv */
// ----------------------------------------------------------------------------
// gnel_pkg
// Shared widths, codes and types of the grid neighbor edge list block.
// ----------------------------------------------------------------------------
`default_nettype none

package gnel_pkg;

  localparam int CELL_W    = 8;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

  // Neighbor codes, in the order their edges are sent.
  localparam logic [1:0] NB_W  = 2'd0;
  localparam logic [1:0] NB_NW = 2'd1;
  localparam logic [1:0] NB_N  = 2'd2;
  localparam logic [1:0] NB_NE = 2'd3;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [3:0] mask;
    coord_t     row;
    coord_t     col;
  } job_t;

endpackage

`default_nettype wire

/* rtl/gnel_emit.sv */
// ----------------------------------------------------------------------------
// gnel_emit
// Holds the free neighbors of one cell and sends their edge pairs, one word
// per cycle while edge_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gnel_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  input  wire gnel_pkg::job_t  job,
  output logic                 job_ready,
  output logic                 edge_valid,
  input  wire logic            edge_stall,
  output gnel_pkg::coord_t     from_row,
  output gnel_pkg::coord_t     from_col,
  output gnel_pkg::coord_t     to_row,
  output gnel_pkg::coord_t     to_col,
  output logic                 diagonal,
  output logic                 last_edge
);

  logic [3:0]       pending;
  logic             half;
  gnel_pkg::coord_t row;
  gnel_pkg::coord_t col;

  logic [1:0]       sel;
  logic [3:0]       sel_bit;
  logic             busy;
  logic             issue;
  logic             last;
  gnel_pkg::coord_t nb_row;
  gnel_pkg::coord_t nb_col;
  logic             nb_diag;

  always_comb begin
    if (pending[gnel_pkg::NB_W]) begin
      sel = gnel_pkg::NB_W;
    end else if (pending[gnel_pkg::NB_NW]) begin
      sel = gnel_pkg::NB_NW;
    end else if (pending[gnel_pkg::NB_N]) begin
      sel = gnel_pkg::NB_N;
    end else begin
      sel = gnel_pkg::NB_NE;
    end
  end

  assign sel_bit   = 4'b0001 << sel;
  assign busy      = pending != 4'b0000;
  assign issue     = busy && (!edge_valid || !edge_stall);
  assign last      = half && ((pending & ~sel_bit) == 4'b0000);
  assign job_ready = !busy || (issue && last);

  always_comb begin
    unique case (sel)
      gnel_pkg::NB_W: begin
        nb_row  = row;
        nb_col  = col - gnel_pkg::COORD_W'(1);
        nb_diag = 1'b0;
      end
      gnel_pkg::NB_NW: begin
        nb_row  = row - gnel_pkg::COORD_W'(1);
        nb_col  = col - gnel_pkg::COORD_W'(1);
        nb_diag = 1'b1;
      end
      gnel_pkg::NB_N: begin
        nb_row  = row - gnel_pkg::COORD_W'(1);
        nb_col  = col;
        nb_diag = 1'b0;
      end
      gnel_pkg::NB_NE: begin
        nb_row  = row - gnel_pkg::COORD_W'(1);
        nb_col  = col + gnel_pkg::COORD_W'(1);
        nb_diag = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 4'b0000;
      half       <= 1'b0;
      edge_valid <= 1'b0;
    end else begin
      if (issue) begin
        edge_valid <= 1'b1;
      end else if (!edge_stall) begin
        edge_valid <= 1'b0;
      end
      if (job_valid && job_ready) begin
        pending <= job.mask;
        half    <= 1'b0;
      end else if (issue) begin
        if (half) begin
          pending <= pending & ~sel_bit;
          half    <= 1'b0;
        end else begin
          half <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      row <= job.row;
      col <= job.col;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      if (!half) begin
        from_row <= nb_row;
        from_col <= nb_col;
        to_row   <= row;
        to_col   <= col;
      end else begin
        from_row <= row;
        from_col <= col;
        to_row   <= nb_row;
        to_col   <= nb_col;
      end
      diagonal  <= nb_diag;
      last_edge <= last;
    end
  end

endmodule

`default_nettype wire

/* rtl/grid_neighbor_edge_list_top.sv */
// ----------------------------------------------------------------------------
// grid_neighbor_edge_list_top
// Turns an occupancy grid, one cell word at a time in raster order, into the
// directed edges of its eight-connected graph of free cells.
// ----------------------------------------------------------------------------
// Cells enter on cell_valid/cell_stall; a nonzero cell_value is free.
// Edges leave on edge_valid/edge_stall, one word per edge, with last_edge
// set on the final edge of a cell. A cell with no free neighbor seen so far
// gives no edge word. Per neighbor (west, north-west, north, north-east) the
// edge toward the cell comes first, then the edge back.
// The first edge word of a cell is valid once the cell's neighbor mask is
// registered in the emitter and then the word in its output stage. Edge
// words leave at one per cycle while edge_stall is low, at most eight per
// cell; once no edges wait, cells with no edge go in at one per cycle.
// A stall on the edge side holds the current word, and while a taken cell
// still has edges waiting the input side stalls as well.
// Reset, and a write to either grid size on the cfg channel, restarts the
// frame at row 0, column 0. Both grid sizes reset to 1024 (MAX_DIM if less).
// The one-row line store is not cleared; the first row ignores what it reads.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_neighbor_edge_list_top #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gnel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gnel_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              cell_valid,
  output logic                                   cell_stall,
  input  wire logic [gnel_pkg::CELL_W-1:0]       cell_value,
  output logic                                   edge_valid,
  input  wire logic                              edge_stall,
  output gnel_pkg::coord_t                       from_row,
  output gnel_pkg::coord_t                       from_col,
  output gnel_pkg::coord_t                       to_row,
  output gnel_pkg::coord_t                       to_col,
  output logic                                   diagonal,
  output logic                                   last_edge
);

  localparam int CW        = $clog2(MAX_DIM);
  localparam int DW        = CW + 1;
  localparam int DIM_RESET = (1024 > MAX_DIM) ? MAX_DIM : 1024;

  function automatic logic [DW-1:0] clamp_dim(input logic [gnel_pkg::CFG_W-1:0] v);
    logic [31:0] w;
    logic [31:0] r;
    w = 32'(v);
    if (w == 32'd0) begin
      r = 32'd1;
    end else if (w > 32'(MAX_DIM)) begin
      r = 32'(MAX_DIM);
    end else begin
      r = w;
    end
    return DW'(r);
  endfunction

  logic [DW-1:0]  grid_rows;
  logic [DW-1:0]  grid_cols;
  logic [CW-1:0]  row_cnt;
  logic [CW-1:0]  col_cnt;
  logic           left_free;
  logic           upper_left_free;
  logic           north_cur;
  logic           row0_free;
  logic           rd_q;
  logic           fwd_sel;
  logic           fwd_val;
  logic           line_store [MAX_DIM];

  logic           accept;
  logic           cfg_write;
  logic           free_now;
  logic           north_next;
  logic           last_col;
  logic           last_row;
  logic [CW-1:0]  col_next;
  logic [CW-1:0]  row_next;
  logic [CW-1:0]  rd_addr;
  logic           has_row;
  logic           has_col;
  logic           job_ready;
  gnel_pkg::job_t job;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign cell_stall = !job_ready;
  assign accept     = cell_valid && !cell_stall;

  assign free_now   = cell_value != '0;
  assign north_next = fwd_sel ? fwd_val : rd_q;
  assign last_col   = ({1'b0, col_cnt} + DW'(1)) >= grid_cols;
  assign last_row   = ({1'b0, row_cnt} + DW'(1)) >= grid_rows;
  assign col_next   = last_col ? '0 : col_cnt + CW'(1);
  assign row_next   = last_row ? '0 : row_cnt + CW'(1);
  assign rd_addr    = col_next + CW'(1);
  assign has_row    = row_cnt != '0;
  assign has_col    = col_cnt != '0;

  always_comb begin
    job.row = gnel_pkg::COORD_W'(row_cnt);
    job.col = gnel_pkg::COORD_W'(col_cnt);
    job.mask[gnel_pkg::NB_W]  = free_now && has_col && left_free;
    job.mask[gnel_pkg::NB_NW] = free_now && has_row && has_col && upper_left_free;
    job.mask[gnel_pkg::NB_N]  = free_now && has_row && north_cur;
    job.mask[gnel_pkg::NB_NE] = free_now && has_row && !last_col && north_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows       <= DW'(DIM_RESET);
      grid_cols       <= DW'(DIM_RESET);
      row_cnt         <= '0;
      col_cnt         <= '0;
      left_free       <= 1'b0;
      upper_left_free <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gnel_pkg::CFG_GRID_ROWS: begin
          grid_rows       <= clamp_dim(cfg_data);
          row_cnt         <= '0;
          col_cnt         <= '0;
          left_free       <= 1'b0;
          upper_left_free <= 1'b0;
        end
        gnel_pkg::CFG_GRID_COLS: begin
          grid_cols       <= clamp_dim(cfg_data);
          row_cnt         <= '0;
          col_cnt         <= '0;
          left_free       <= 1'b0;
          upper_left_free <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      left_free       <= free_now;
      upper_left_free <= north_cur;
      col_cnt         <= col_next;
      if (last_col) begin
        row_cnt <= row_next;
      end
    end
  end

  // The north flags of the next cell come from the current pair, or at a row
  // start from this row's first two cells.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!has_col) begin
        row0_free <= free_now;
      end
      if (last_col) begin
        north_cur <= has_col ? row0_free : free_now;
      end else begin
        north_cur <= north_next;
      end
      fwd_sel <= rd_addr == col_cnt;
      fwd_val <= free_now;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_store[col_cnt] <= free_now;
      rd_q                <= line_store[rd_addr];
    end
  end

  gnel_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (accept),
    .job        (job),
    .job_ready  (job_ready),
    .edge_valid (edge_valid),
    .edge_stall (edge_stall),
    .from_row   (from_row),
    .from_col   (from_col),
    .to_row     (to_row),
    .to_col     (to_col),
    .diagonal   (diagonal),
    .last_edge  (last_edge)
  );

endmodule

`default_nettype wire

/* rtl/gnel_checker.sv */
// ----------------------------------------------------------------------------
// gnel_checker
// Port-level checks of the grid neighbor edge list block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_neighbor_edge_list_top_defines.svh"

module gnel_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             edge_valid,
  input wire logic             edge_stall,
  input wire gnel_pkg::coord_t from_row,
  input wire gnel_pkg::coord_t from_col,
  input wire gnel_pkg::coord_t to_row,
  input wire gnel_pkg::coord_t to_col,
  input wire logic             diagonal,
  input wire logic             last_edge
);

  logic edge_take;
  logic edge_held;
  logic is_diag;

  assign edge_take = edge_valid && !edge_stall;
  assign edge_held = edge_valid && edge_stall;
  assign is_diag   = (from_row != to_row) && (from_col != to_col);

  `GNEL_ASSERT_NEXT(a_edge_held_valid, edge_held, edge_valid)
  `GNEL_ASSERT_NEXT(a_edge_held_data, edge_held, $stable(from_row) && $stable(to_col))
  `GNEL_ASSERT_NEXT(a_cell_continues, edge_take && !last_edge, edge_valid)
  `GNEL_ASSERT_NOW(a_diag_matches, edge_valid, diagonal == is_diag)

endmodule

bind grid_neighbor_edge_list_top gnel_checker u_checker (.*);

`default_nettype wire

/* test/tb_grid_neighbor_edge_list_top.sv */
// ----------------------------------------------------------------------------
// tb_grid_neighbor_edge_list_top
// Self-checking bench for the eight-connected grid edge generator. Cell words
// are fed in raster order under random sender gaps and receiver stalls. A
// built-in predictor tracks the line store, the neighbor flags and the
// row/column position, and every edge word is compared in order against it.
// Tests cover reset sizes, a small hand-built grid, a full-width row and a
// full-height column with sizes clamped at the limits, random small frames,
// a long output hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_neighbor_edge_list_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_MAX      = 1024;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCH_LIMIT  = 2000;

  localparam logic [gnel_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

  typedef logic [gnel_pkg::CELL_W-1:0]    cell_byte_t;
  typedef logic [gnel_pkg::CFG_W-1:0]     cfg_word_t;
  typedef logic [gnel_pkg::CFG_IDX_W-1:0] cfg_index_t;

  typedef struct packed {
    gnel_pkg::coord_t from_row;
    gnel_pkg::coord_t from_col;
    gnel_pkg::coord_t to_row;
    gnel_pkg::coord_t to_col;
    logic             diagonal;
    logic             last_edge;
  } edge_word_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_index_t       cfg_index;
  cfg_word_t        cfg_data;
  logic             cell_valid;
  logic             cell_stall;
  cell_byte_t       cell_value;
  logic             edge_valid;
  logic             edge_stall;
  gnel_pkg::coord_t from_row;
  gnel_pkg::coord_t from_col;
  gnel_pkg::coord_t to_row;
  gnel_pkg::coord_t to_col;
  logic             diagonal;
  logic             last_edge;

  grid_neighbor_edge_list_top #(
    .MAX_DIM(DIM_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .cell_value(cell_value),
    .edge_valid(edge_valid),
    .edge_stall(edge_stall),
    .from_row(from_row),
    .from_col(from_col),
    .to_row(to_row),
    .to_col(to_col),
    .diagonal(diagonal),
    .last_edge(last_edge)
  );

  always #2 clk = ~clk;

  // Predictor state.
  int  frame_rows = DIM_MAX;
  int  frame_cols = DIM_MAX;
  bit  line_free [DIM_MAX];
  bit  nw_free = 1'b0;
  bit  w_free = 1'b0;
  int  pos_row = 0;
  int  pos_col = 0;
  edge_word_t pending_edges[$];

  int  cells_sent = 0;
  int  cfg_words = 0;
  int  edges_checked = 0;
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  hold_out = 1'b0;
  bit  calm = 1'b0;

  function automatic int fit_size(input cfg_word_t v);
    if (v == '0) return 1;
    if (int'(v) > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  task automatic apply_cfg(input cfg_index_t idx, input cfg_word_t v);
    bit hit;
    hit = 1'b1;
    if (idx == gnel_pkg::CFG_GRID_ROWS) begin
      frame_rows = fit_size(v);
    end else if (idx == gnel_pkg::CFG_GRID_COLS) begin
      frame_cols = fit_size(v);
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      pos_row = 0;
      pos_col = 0;
      w_free = 1'b0;
      nw_free = 1'b0;
    end
    cfg_words++;
  endtask

  task automatic predict_edges(input cell_byte_t value);
    bit         cell_free;
    bit         north;
    logic [3:0] hit;
    logic [3:0] diag_of;
    int         nr [4];
    int         nc [4];
    int         final_nb;
    edge_word_t w;
    cell_free = (value != '0);
    north = line_free[pos_col % DIM_MAX];
    hit = '0;
    diag_of = '0;
    diag_of[gnel_pkg::NB_NW] = 1'b1;
    diag_of[gnel_pkg::NB_NE] = 1'b1;
    nr[gnel_pkg::NB_W]  = pos_row;     nc[gnel_pkg::NB_W]  = pos_col - 1;
    nr[gnel_pkg::NB_NW] = pos_row - 1; nc[gnel_pkg::NB_NW] = pos_col - 1;
    nr[gnel_pkg::NB_N]  = pos_row - 1; nc[gnel_pkg::NB_N]  = pos_col;
    nr[gnel_pkg::NB_NE] = pos_row - 1; nc[gnel_pkg::NB_NE] = pos_col + 1;
    if (cell_free) begin
      hit[gnel_pkg::NB_W]  = (pos_col > 0) && w_free;
      hit[gnel_pkg::NB_NW] = (pos_row > 0) && (pos_col > 0) && nw_free;
      hit[gnel_pkg::NB_N]  = (pos_row > 0) && north;
      hit[gnel_pkg::NB_NE] = (pos_row > 0) && (pos_col + 1 < frame_cols) &&
                             line_free[(pos_col + 1) % DIM_MAX];
    end
    final_nb = -1;
    for (int j = 0; j < 4; j++) begin
      if (hit[j]) final_nb = j;
    end
    for (int j = 0; j < 4; j++) begin
      if (hit[j]) begin
        w.from_row  = gnel_pkg::coord_t'(nr[j]);
        w.from_col  = gnel_pkg::coord_t'(nc[j]);
        w.to_row    = gnel_pkg::coord_t'(pos_row);
        w.to_col    = gnel_pkg::coord_t'(pos_col);
        w.diagonal  = diag_of[j];
        w.last_edge = 1'b0;
        pending_edges.insert(pending_edges.size(), w);
        w.from_row  = gnel_pkg::coord_t'(pos_row);
        w.from_col  = gnel_pkg::coord_t'(pos_col);
        w.to_row    = gnel_pkg::coord_t'(nr[j]);
        w.to_col    = gnel_pkg::coord_t'(nc[j]);
        w.last_edge = (j == final_nb);
        pending_edges.insert(pending_edges.size(), w);
      end
    end
    nw_free = north;
    w_free = cell_free;
    line_free[pos_col % DIM_MAX] = cell_free;
    pos_col++;
    if (pos_col >= frame_cols) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= frame_rows) pos_row = 0;
    end
  endtask

  function automatic cell_byte_t random_cell(input int free_pct);
    if ($urandom_range(1, 100) <= free_pct) return cell_byte_t'($urandom_range(1, 255));
    return '0;
  endfunction

  task automatic send_cell(input cell_byte_t value);
    cell_valid <= 1'b1;
    cell_value <= value;
    do @(posedge clk); while (cell_stall);
    predict_edges(value);
    cells_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      cell_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    cell_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input cfg_word_t rows_word, input cfg_word_t cols_word,
                          input bit poke_spare);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= gnel_pkg::CFG_GRID_ROWS;
    cfg_data  <= rows_word;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(gnel_pkg::CFG_GRID_ROWS, rows_word);
    cfg_index <= gnel_pkg::CFG_GRID_COLS;
    cfg_data  <= cols_word;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(gnel_pkg::CFG_GRID_COLS, cols_word);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_data  <= cfg_word_t'($urandom_range(0, 2047));
      do @(posedge clk); while (!cfg_ready);
      apply_cfg(CFG_SPARE, '0);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    cell_byte_t pattern [15];
    pattern = '{8'hFF, 8'h01, 8'h80, 8'h00,
                8'h55, 8'hAA, 8'hFF, 8'h02,
                8'h00, 8'h40, 8'h00, 8'h00,
                8'h20, 8'h00, 8'h10};
    send_cell(8'hFF);
    send_cell(8'h08);
    set_grid(cfg_word_t'(3), cfg_word_t'(4), 1'b1);
    foreach (pattern[i]) send_cell(pattern[i]);
  endtask

  task automatic test_wide_row();
    set_grid(cfg_word_t'(0), cfg_word_t'(2047), 1'b1);
    repeat (40) send_cell(random_cell(80));
  endtask

  task automatic test_tall_column();
    set_grid(cfg_word_t'(1025), cfg_word_t'(1), 1'b0);
    repeat (40) send_cell(random_cell(85));
  endtask

  task automatic test_random_frames();
    int total;
    int count;
    int density;
    total = 0;
    while (total < 70) begin
      set_grid(cfg_word_t'($urandom_range(0, 6)), cfg_word_t'($urandom_range(0, 9)), 1'b0);
      count = $urandom_range(15, 45);
      density = $urandom_range(55, 98);
      repeat (count) send_cell(random_cell(density));
      total += count;
    end
  endtask

  task automatic test_output_hold();
    set_grid(cfg_word_t'(4), cfg_word_t'(6), 1'b0);
    hold_out = 1'b1;
    repeat (30) send_cell(random_cell(100));
  endtask

  task automatic test_full_rate();
    set_grid(cfg_word_t'(5), cfg_word_t'(7), 1'b0);
    calm = 1'b1;
    repeat (50) send_cell(random_cell(90));
  endtask

  // Receiver pacing: random stall bursts, one long hold-off on request,
  // and no stalls once the bench is calm.
  initial begin : edge_pacer
    edge_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        edge_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else if (calm) begin
        edge_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        edge_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        edge_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : edge_check
    edge_word_t got;
    edge_word_t want;
    if (!rst && edge_valid && !edge_stall) begin
      got = {from_row, from_col, to_row, to_col, diagonal, last_edge};
      edges_checked++;
      if (pending_edges.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected edge word (%0d,%0d)->(%0d,%0d) diag %0b last %0b",
                 $time, got.from_row, got.from_col, got.to_row, got.to_col,
                 got.diagonal, got.last_edge);
      end else begin
        want = pending_edges.pop_front();
        if (got !== want) begin
          fail_count++;
          $display({"%0t: edge mismatch: expected (%0d,%0d)->(%0d,%0d) diag %0b last %0b,",
                    " got (%0d,%0d)->(%0d,%0d) diag %0b last %0b"},
                   $time, want.from_row, want.from_col, want.to_row, want.to_col,
                   want.diagonal, want.last_edge, got.from_row, got.from_col,
                   got.to_row, got.to_col, got.diagonal, got.last_edge);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cell_valid && !cell_stall) || (edge_valid && !edge_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d edges still expected",
               $time, idle_cycles, pending_edges.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= gnel_pkg::CFG_GRID_ROWS;
    cfg_data   <= '0;
    cell_valid <= 1'b0;
    cell_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_wide_row();
    test_tall_column();
    test_random_frames();
    test_output_hold();
    test_full_rate();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d cell words and %0d register words over grids from 1x1",
             cells_sent, cfg_words);
    $display("to 1024 on a side, with gaps, stalls and a long hold; %0d edges, %0d bad.",
             edges_checked, fail_count);
    if (fail_count == 0 && pending_edges.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/gnel_pkg.sv
rtl/gnel_emit.sv
rtl/grid_neighbor_edge_list_top.sv
rtl/gnel_checker.sv
test/tb_grid_neighbor_edge_list_top.sv
